/* hdl/m4rt_pkg.sv */
// shared types and constants for the 4x4 fixed-point row transform
// no dependencies; imported by the lane, merge and top-level modules
package m4rt_pkg;

  localparam int unsigned Dim      = 4;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned RegIdxW  = $clog2(NumRegs);
  localparam int unsigned FracBits = 16;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned SumW     = 66;
  localparam int unsigned ShW      = SumW - FracBits;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [SumW-1:0] sum_t;
  typedef logic [63:0] cfg_word_t;

  typedef struct packed {
    q16_t res;
    logic sat;
  } lane_out_t;

  localparam q16_t Q16Max = 32'sh7fff_ffff;
  localparam q16_t Q16Min = 32'sh8000_0000;

  // reset values give the identity matrix
  localparam cfg_word_t RightResetVals [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000,
    64'h0, 64'h0001_0000_0000_0000
  };

endpackage

/* hdl/m4rt_lane.sv */
// one output column: four multipliers, a summing stage and shift/saturate
// depends on m4rt_pkg
module m4rt_lane
  import m4rt_pkg::*;
(
  input  logic      clk_i,
  input  q16_t      left_i [Dim],
  input  q16_t      col_i  [Dim],
  output lane_out_t out_o
);

  prod_t     prod_q [Dim];
  sum_t      sum_d, sum_q;
  logic signed [ShW-1:0] sh;
  lane_out_t out_d, out_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Dim; k++) begin
      prod_q[k] <= left_i[k] * col_i[k];
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < Dim; k++) begin
      sum_d = sum_d + SumW'(prod_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  // floor division by 2^16 of the exact sum, then clamp to 32 bits
  always_comb begin
    sh = sum_q[SumW-1:FracBits];
    if ((&sh[ShW-1:31]) || !(|sh[ShW-1:31])) begin
      out_d.res = sh[31:0];
      out_d.sat = 1'b0;
    end else begin
      out_d.res = sh[ShW-1] ? Q16Min : Q16Max;
      out_d.sat = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_o = out_q;

endmodule

/* hdl/m4rt_merge.sv */
// merges the four lane results into one output row with a combined flag
// depends on m4rt_pkg
module m4rt_merge
  import m4rt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  lane_out_t lane_i [Dim],
  output logic      done_o,
  output q16_t      prod_o [Dim],
  output logic      sat_o
);

  logic done_q;
  q16_t prod_q [Dim];
  logic sat_d, sat_q;

  always_comb begin
    sat_d = 1'b0;
    for (int j = 0; j < Dim; j++) begin
      sat_d = sat_d | lane_i[j].sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < Dim; j++) begin
      prod_q[j] <= lane_i[j].res;
    end
    sat_q <= sat_d;
  end

  assign done_o = done_q;
  assign prod_o = prod_q;
  assign sat_o  = sat_q;

endmodule

/* hdl/matrix4_row_transform.sv */
// top level of the 4x4 fixed-point row transform: config registers, lanes, merge
// depends on m4rt_pkg, m4rt_lane and m4rt_merge
//
// Usage:
//   Each request carries one row of the left matrix (left_c0_i..left_c3_i,
//   signed Q16.16) and is taken on a clock edge with start high and busy low.
//   busy is never raised, so a new row may be issued every cycle.
//   The product row appears on prod_c0_o..prod_c3_o with saturated_o for
//   exactly one cycle while done_o is high.
//   Throughput is one row per cycle; latency is set by the multiplier
//   register, the summing register, the saturation register and the merge
//   output register in turn.
//   The right matrix lives in eight 64-bit registers written through
//   cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; cfg_ready_o is
//   always high and writes to indexes past the last register are dropped.
//   Reset clears the valid pipeline and done_o and loads the identity matrix.
//   The receiver cannot stall: each result is shown once and must be taken.
module matrix4_row_transform
  import m4rt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  q16_t               left_c0_i,
  input  q16_t               left_c1_i,
  input  q16_t               left_c2_i,
  input  q16_t               left_c3_i,
  output logic               done_o,
  output q16_t               prod_c0_o,
  output q16_t               prod_c1_o,
  output q16_t               prod_c2_o,
  output q16_t               prod_c3_o,
  output logic               saturated_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  cfg_word_t          cfg_data_i
);

  cfg_word_t right_q [NumRegs];
  logic [2:0] vld_q;
  logic       accept;
  logic       cfg_we;
  q16_t       left [Dim];
  q16_t       col  [Dim][Dim];
  lane_out_t  lane_out [Dim];
  q16_t       prod [Dim];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o && (cfg_index_i < CfgIdxW'(NumRegs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        right_q[i] <= RightResetVals[i];
      end
    end else if (cfg_we) begin
      right_q[cfg_index_i[RegIdxW-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], accept};
    end
  end

  assign left[0] = left_c0_i;
  assign left[1] = left_c1_i;
  assign left[2] = left_c2_i;
  assign left[3] = left_c3_i;

  for (genvar j = 0; j < Dim; j++) begin : g_lane
    for (genvar k = 0; k < Dim; k++) begin : g_elem
      assign col[j][k] = right_q[2*k + j/2][32*(j%2) +: 32];
    end

    m4rt_lane u_lane (
      .clk_i  (clk_i),
      .left_i (left),
      .col_i  (col[j]),
      .out_o  (lane_out[j])
    );
  end

  m4rt_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[2]),
    .lane_i  (lane_out),
    .done_o  (done_o),
    .prod_o  (prod),
    .sat_o   (saturated_o)
  );

  assign prod_c0_o = prod[0];
  assign prod_c1_o = prod[1];
  assign prod_c2_o = prod[2];
  assign prod_c3_o = prod[3];

  a_done_follows_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vld_q[2]))
    else $error("result strobe without a row in the last lane stage");

  a_sat_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (prod_c0_o == Q16Max || prod_c0_o == Q16Min ||
       prod_c1_o == Q16Max || prod_c1_o == Q16Min ||
       prod_c2_o == Q16Max || prod_c2_o == Q16Min ||
       prod_c3_o == Q16Max || prod_c3_o == Q16Min))
    else $error("saturation flag set but no column is clamped");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we |=> (right_q[$past(cfg_index_i[RegIdxW-1:0])] == $past(cfg_data_i)))
    else $error("configuration write did not land");

  a_pipe_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted row not tracked by the valid pipeline");

endmodule
